### hdl/vie_pkg.sv
// Package for the variable-length integer encoder.
// Holds the queue entry type and the encoding constants; no dependencies.
package vie_pkg;

   localparam int unsigned WORD_BITS   = 64;
   localparam int unsigned GROUP_BITS  = 7;
   localparam int unsigned GROUPS      = 8;
   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int unsigned QFILL_BITS  = $clog2(QUEUE_DEPTH + 1);

   localparam logic [3:0] MAX_WIDTH  = 4'd8;
   localparam logic [3:0] LAST_GROUP = 4'(GROUPS);
   localparam logic [7:0] MORE_FLAG  = 8'h80;

   localparam logic STATUS_OK  = 1'b0;
   localparam logic STATUS_ERR = 1'b1;

   // one classified integer, ready to be serialised
   typedef struct packed {
      logic [WORD_BITS-1:0] word;
      logic [3:0]           count;
      logic                 status;
   } vie_entry_type;

endpackage

### hdl/vie_if.sv
// Channel interfaces for the encoder: integer requests and code-byte responses.
// Depends on nothing.
interface vie_req_if;
   logic        valid;
   logic        ready;
   logic [63:0] value;
   logic [3:0]  width_bytes;
   logic        twos_comp;

   modport source (output valid, value, width_bytes, twos_comp, input ready);
   modport sink   (input valid, value, width_bytes, twos_comp, output ready);
endinterface

interface vie_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] code_byte;
   logic       last;
   logic [3:0] byte_count;
   logic       status;

   modport source (output valid, code_byte, last, byte_count, status, input ready);
   modport sink   (input valid, code_byte, last, byte_count, status, output ready);
endinterface

### hdl/vie_front.sv
// Front end: masks, sign-folds and sizes one integer per cycle.
// Depends on vie_pkg.
module vie_front (
   input  logic [63:0]            value,
   input  logic [3:0]             width_bytes,
   input  logic                   twos_comp,
   output vie_pkg::vie_entry_type entry
);

   logic [63:0] mask;
   logic [63:0] masked;
   logic [63:0] negated;
   logic [63:0] word;
   logic        sign_bit;
   logic        bad_width;
   logic [8:0]  group_nz;
   logic [3:0]  count;

   always_comb begin
      mask     = '0;
      sign_bit = 1'b0;
      for (int b = 0; b < 8; b++) begin
         if (width_bytes > 4'(b)) begin
            mask[8*b +: 8] = 8'hff;
         end
         if (width_bytes == 4'(b + 1)) begin
            sign_bit = value[8*b + 7];
         end
      end
   end

   assign bad_width = (width_bytes == 4'd0) || (width_bytes > vie_pkg::MAX_WIDTH);
   assign masked    = value & mask;
   assign negated   = (~masked + 64'd1) & mask;

   always_comb begin
      if (bad_width) begin
         word = '0;
      end else if (!twos_comp) begin
         word = masked;
      end else if (sign_bit) begin
         word = {negated[62:0], 1'b1};
      end else begin
         word = {masked[62:0], 1'b0};
      end
   end

   // the highest group holding any set bit fixes the length
   always_comb begin
      for (int g = 0; g < 8; g++) begin
         group_nz[g] = |word[7*g +: 7];
      end
      group_nz[8] = |word[63:56];
      count = 4'd1;
      for (int g = 0; g < 9; g++) begin
         if (group_nz[g]) begin
            count = 4'(g + 1);
         end
      end
   end

   always_comb begin
      entry.word   = word;
      entry.count  = bad_width ? 4'd0 : count;
      entry.status = bad_width ? vie_pkg::STATUS_ERR : vie_pkg::STATUS_OK;
   end

endmodule

### hdl/vie_queue.sv
// Two-entry queue between front and back ends.
// Depends on vie_pkg.
module vie_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  vie_pkg::vie_entry_type push_entry,
   output logic                   full,
   input  logic                   pop,
   output logic                   not_empty,
   output vie_pkg::vie_entry_type head
);

   vie_pkg::vie_entry_type               slot_ff [vie_pkg::QUEUE_DEPTH];
   logic [vie_pkg::QPTR_BITS-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [vie_pkg::QPTR_BITS-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [vie_pkg::QFILL_BITS-1:0]       fill_ff, fill_in;

   assign full      = (fill_ff == vie_pkg::QFILL_BITS'(vie_pkg::QUEUE_DEPTH));
   assign not_empty = (fill_ff != '0);
   assign head      = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      fill_in   = fill_ff;
      if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

endmodule

### hdl/vie_back.sv
// Back end: serialises a queued word into code bytes through an output register.
// Depends on vie_pkg.
module vie_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   q_valid,
   input  vie_pkg::vie_entry_type q_head,
   output logic                   q_pop,
   output logic                   out_valid,
   input  logic                   out_ready,
   output logic [7:0]             out_byte,
   output logic                   out_last,
   output logic [3:0]             out_count,
   output logic                   out_status
);

   logic        busy_ff, busy_in;
   logic [63:0] word_ff, word_in;
   logic [3:0]  idx_ff, idx_in;
   logic [3:0]  cnt_ff, cnt_in;
   logic        err_ff, err_in;

   logic        ovalid_ff, ovalid_in;
   logic [7:0]  obyte_ff, obyte_in;
   logic        olast_ff, olast_in;
   logic [3:0]  ocount_ff, ocount_in;
   logic        ostatus_ff, ostatus_in;

   logic        out_free;
   logic        emit;
   logic [3:0]  idx_next;
   logic        is_last;
   logic [7:0]  code;

   assign out_free = !ovalid_ff || out_ready;
   assign emit     = busy_ff && out_free;
   assign idx_next = idx_ff + 4'd1;
   assign is_last  = err_ff || (idx_next == cnt_ff);
   assign q_pop    = q_valid && (!busy_ff || (emit && is_last));

   always_comb begin
      if (idx_ff == vie_pkg::LAST_GROUP) begin
         code = word_ff[7:0];
      end else if (idx_next < cnt_ff) begin
         code = vie_pkg::MORE_FLAG | {1'b0, word_ff[6:0]};
      end else begin
         code = {1'b0, word_ff[6:0]};
      end
   end

   always_comb begin
      busy_in = busy_ff;
      word_in = word_ff;
      idx_in  = idx_ff;
      cnt_in  = cnt_ff;
      err_in  = err_ff;
      if (emit) begin
         word_in = word_ff >> vie_pkg::GROUP_BITS;
         idx_in  = idx_next;
         if (is_last) begin
            busy_in = 1'b0;
         end
      end
      if (q_pop) begin
         busy_in = 1'b1;
         word_in = q_head.word;
         idx_in  = '0;
         cnt_in  = q_head.count;
         err_in  = q_head.status;
      end
   end

   always_comb begin
      ovalid_in  = ovalid_ff && !out_ready;
      obyte_in   = obyte_ff;
      olast_in   = olast_ff;
      ocount_in  = ocount_ff;
      ostatus_in = ostatus_ff;
      if (emit) begin
         ovalid_in  = 1'b1;
         obyte_in   = code;
         olast_in   = is_last;
         ocount_in  = cnt_ff;
         ostatus_in = err_ff;
      end
   end

   always_ff @(posedge clock) begin
      word_ff    <= word_in;
      idx_ff     <= idx_in;
      cnt_ff     <= cnt_in;
      err_ff     <= err_in;
      obyte_ff   <= obyte_in;
      olast_ff   <= olast_in;
      ocount_ff  <= ocount_in;
      ostatus_ff <= ostatus_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff   <= 1'b0;
         ovalid_ff <= 1'b0;
      end else begin
         busy_ff   <= busy_in;
         ovalid_ff <= ovalid_in;
      end
   end

   assign out_valid  = ovalid_ff;
   assign out_byte   = obyte_ff;
   assign out_last   = olast_ff;
   assign out_count  = ocount_ff;
   assign out_status = ostatus_ff;

endmodule

### hdl/varint_integer_encoder.sv
// Variable-length (LEB128 style, sign in bit 0) integer encoder, top level.
// Depends on vie_pkg, vie_if, vie_front, vie_queue and vie_back.
//
// Usage:
//  - req_chan carries one integer per transfer: value, width_bytes (1..8)
//    and twos_comp. Bits above width_bytes*8 are ignored.
//  - rsp_chan returns one code byte per transfer, least significant group
//    first; last marks the final byte, byte_count is the total length.
//  - A bad width (0 or above 8) gives a single transfer with status set,
//    byte_count 0, code_byte 0 and last set.
//  - The first byte passes through the queue, the serialiser and the output register.
//  - One code byte per cycle while the receiver is ready, set by the back-end
//    serialiser; an integer of n bytes (1 to 9) holds it until its last byte is sent.
//  - Requests are taken while the two-entry queue has room, so new
//    integers keep arriving while earlier ones are still being sent.
//  - Reset (synchronous) empties the queue and drops any byte in flight.
//  - A stalled receiver holds the output register; the serialiser and then
//    the queue fill up and req_chan.ready falls, with no byte lost.
module varint_integer_encoder (
   input  logic      clock,
   input  logic      reset,
   vie_req_if.sink   req_chan,
   vie_rsp_if.source rsp_chan
);

   vie_pkg::vie_entry_type front_entry;
   vie_pkg::vie_entry_type q_head;
   logic                   q_full;
   logic                   q_valid;
   logic                   q_pop;
   logic                   push;

   // front: classify straight off the channel
   vie_front u_front (
      .value       (req_chan.value),
      .width_bytes (req_chan.width_bytes),
      .twos_comp   (req_chan.twos_comp),
      .entry       (front_entry)
   );

   assign req_chan.ready = !q_full;
   assign push           = req_chan.valid && !q_full;

   // decoupling queue
   vie_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (front_entry),
      .full       (q_full),
      .pop        (q_pop),
      .not_empty  (q_valid),
      .head       (q_head)
   );

   // back: byte serialiser with registered output
   vie_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_head     (q_head),
      .q_pop      (q_pop),
      .out_valid  (rsp_chan.valid),
      .out_ready  (rsp_chan.ready),
      .out_byte   (rsp_chan.code_byte),
      .out_last   (rsp_chan.last),
      .out_count  (rsp_chan.byte_count),
      .out_status (rsp_chan.status)
   );

endmodule

### sim/tb.sv
// Self-checking testbench for varint_integer_encoder: directed and random integers in,
// code bytes checked against a local model of the encoding.
// Depends on vie_pkg, vie_if and the encoder RTL.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [63:0] GROUP_MASK  = 64'h7f;
   localparam logic [63:0] FULL_BYTE   = 64'hff;
   localparam int          CYCLE_LIMIT = 600000;
   localparam int          TAIL_CYCLES = 20;
   localparam int          PRINT_CAP   = 50;

   // one expected code-byte transfer
   typedef struct packed {
      logic [7:0] code_byte;
      logic       last;
      logic [3:0] byte_count;
      logic       status;
   } code_byte_type;

   logic clock = 1'b0;
   logic reset;

   vie_req_if req_chan ();
   vie_rsp_if rsp_chan ();

   varint_integer_encoder u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // code bytes still owed by the encoder, oldest first
   code_byte_type pending_bytes[$];

   int mismatches    = 0;
   int cycles        = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // watchdog: a hung handshake or a missing byte ends the run here
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   task automatic report_mismatch(input string msg);
      if (mismatches < PRINT_CAP)
         $display("[%0t] mismatch: %s", $realtime, msg);
      mismatches++;
   endtask

   // position of the highest set bit plus one; zero for a zero word
   function automatic int significant_bits(input logic [63:0] word);
      int n;
      n = 0;
      for (int i = 0; i < 64; i++)
         if (word[i])
            n = i + 1;
      return n;
   endfunction

   // Works out the code bytes for one integer and appends them to pending_bytes.
   function automatic void predict_code_bytes(input logic [63:0] value,
                                              input logic [3:0] width_bytes,
                                              input logic twos_comp);
      logic [63:0]   mask;
      logic [63:0]   word;
      logic          neg;
      int            nbits;
      logic [3:0]    count;
      int            k;
      code_byte_type cb;

      if (width_bytes == 4'd0 || width_bytes > vie_pkg::MAX_WIDTH) begin
         cb = '{code_byte: 8'h00, last: 1'b1, byte_count: 4'd0,
                status: vie_pkg::STATUS_ERR};
         pending_bytes.push_back(cb);
         return;
      end

      mask = (width_bytes == vie_pkg::MAX_WIDTH) ? '1
                                                 : ((64'd1 << (width_bytes * 8)) - 64'd1);
      word = value & mask;

      // signed: magnitude at the given width, shifted up, sign in bit 0
      if (twos_comp) begin
         neg = word[width_bytes * 8 - 1];
         if (neg)
            word = (~word + 64'd1) & mask;
         word = {word[62:0], neg};
      end

      nbits = significant_bits(word);
      if (nbits == 0)
         nbits = 1;
      count = (nbits == 64) ? 4'd9 : 4'((nbits + 6) / 7);

      if (word == '0) begin
         cb = '{code_byte: 8'h00, last: 1'b1, byte_count: count,
                status: vie_pkg::STATUS_OK};
         pending_bytes.push_back(cb);
         return;
      end

      k = 0;
      while (k < vie_pkg::GROUPS && word != '0) begin
         cb.code_byte  = 8'(word & GROUP_MASK);
         word          = word >> vie_pkg::GROUP_BITS;
         if (word != '0)
            cb.code_byte = cb.code_byte | vie_pkg::MORE_FLAG;
         cb.last       = (word == '0);
         cb.byte_count = count;
         cb.status     = vie_pkg::STATUS_OK;
         pending_bytes.push_back(cb);
         k++;
      end
      // ninth byte carries a full eight bits, no continuation flag
      if (word != '0) begin
         cb = '{code_byte: 8'(word & FULL_BYTE), last: 1'b1, byte_count: count,
                status: vie_pkg::STATUS_OK};
         pending_bytes.push_back(cb);
      end
   endfunction

   // Receiver: ready changes only at the falling edge, idling at the current rate.
   initial begin
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_chan.ready <= !reset && ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Response checker: every accepted transfer is matched with the oldest expectation.
   always @(posedge clock) begin
      code_byte_type got;
      code_byte_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         got = '{code_byte: rsp_chan.code_byte, last: rsp_chan.last,
                 byte_count: rsp_chan.byte_count, status: rsp_chan.status};
         if (pending_bytes.size() == 0) begin
            report_mismatch($sformatf("unexpected byte %02h last %0b count %0d status %0b",
                                      got.code_byte, got.last, got.byte_count, got.status));
         end else begin
            want = pending_bytes.pop_front();
            if (got !== want)
               report_mismatch($sformatf(
                  "byte %02h/%02h last %0b/%0b count %0d/%0d status %0b/%0b (got/exp)",
                  got.code_byte, want.code_byte, got.last, want.last,
                  got.byte_count, want.byte_count, got.status, want.status));
         end
      end
   end

   // Sends one integer. Valid is only ever changed at a falling edge, and a
   // back-to-back transfer simply leaves it high, so there is one assignment per step.
   task automatic send_integer(input logic [63:0] value, input logic [3:0] width_bytes,
                               input logic twos_comp);
      bit idle;
      idle = 1'b1;
      while (idle) begin
         @(negedge clock);
         if ($urandom_range(99) < send_idle_pct) begin
            req_chan.valid       <= 1'b0;
            req_chan.value       <= {$urandom, $urandom};
            req_chan.width_bytes <= 4'($urandom);
            req_chan.twos_comp   <= 1'($urandom);
            @(posedge clock);
         end else begin
            idle = 1'b0;
         end
      end
      req_chan.valid       <= 1'b1;
      req_chan.value       <= value;
      req_chan.width_bytes <= width_bytes;
      req_chan.twos_comp   <= twos_comp;
      do
         @(posedge clock);
      while (!req_chan.ready);
      predict_code_bytes(value, width_bytes, twos_comp);
   endtask

   // Drops valid and holds off until the encoder has delivered everything owed.
   task automatic wait_until_drained();
      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (pending_bytes.size() != 0)
         @(posedge clock);
   endtask

   // Random integer biased towards every encoded length and the sign boundary.
   function automatic logic [63:0] random_value();
      logic [63:0] raw;
      int          shift;
      raw   = {$urandom, $urandom};
      shift = $urandom_range(63);
      case ($urandom_range(4))
         0:       return raw;
         1:       return raw >> shift;
         2:       return ~(raw >> shift);          // small negative at most widths
         3:       return (64'd1 << shift) - 64'd1; // all-ones run
         default: return 64'd1 << shift;           // single bit
      endcase
   endfunction

   task automatic test_invalid_width();
      send_integer(64'h0123_4567_89ab_cdef, 4'd0, 1'b0);
      send_integer(64'hffff_ffff_ffff_ffff, 4'd9, 1'b1);
      send_integer(64'h0000_0000_0000_0001, 4'd15, 1'b0);
      send_integer(64'h8000_0000_0000_0000, 4'd12, 1'b1);
   endtask

   task automatic test_zero_and_small();
      send_integer(64'h0, 4'd1, 1'b0);                   // zero word, unsigned
      send_integer(64'h0, 4'd8, 1'b1);                   // zero word, signed
      send_integer(64'hffff_ffff_ffff_ff7f, 4'd1, 1'b0); // upper bits masked off
      send_integer(64'h80, 4'd1, 1'b0);                  // first two-byte code
      send_integer(64'hff, 4'd1, 1'b1);                  // minus one
      send_integer(64'h80, 4'd1, 1'b1);                  // most negative byte
      send_integer(64'h7f, 4'd1, 1'b1);                  // most positive byte
   endtask

   task automatic test_signed_extremes();
      send_integer(64'h8000_0000_0000_0000, 4'd8, 1'b1); // shift drops out of range
      send_integer(64'h7fff_ffff_ffff_ffff, 4'd8, 1'b1);
      send_integer(64'hffff_ffff_ffff_ffff, 4'd8, 1'b1);
      send_integer(64'h0000_0000_8000_0000, 4'd4, 1'b1);
      send_integer(64'h0000_ffff_ffff_ffff, 4'd6, 1'b1);
   endtask

   task automatic test_length_boundaries();
      send_integer(64'hffff_ffff_ffff_ffff, 4'd8, 1'b0); // 64 bits, nine bytes
      send_integer(64'h0100_0000_0000_0000, 4'd8, 1'b0); // 57 bits, nine bytes
      send_integer(64'h00ff_ffff_ffff_ffff, 4'd8, 1'b0); // 56 bits, eight bytes
      for (int w = 2; w <= 7; w++)
         send_integer('1, 4'(w), 1'(w & 1));
   endtask

   task automatic test_random_traffic(input int send_pct, input int recv_pct,
                                      input int items, input bit pause_midway);
      logic [3:0] width_bytes;
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      for (int i = 0; i < items; i++) begin
         if ($urandom_range(99) < 6)
            width_bytes = $urandom_range(1) ? 4'd0 : 4'($urandom_range(15, 9));
         else
            width_bytes = 4'($urandom_range(8, 1));
         send_integer(random_value(), width_bytes, 1'($urandom));
         if (pause_midway && i == items / 2)
            wait_until_drained();
      end
   endtask

   initial begin
      reset                = 1'b1;
      req_chan.valid       = 1'b0;
      req_chan.value       = '0;
      req_chan.width_bytes = '0;
      req_chan.twos_comp   = 1'b0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed part runs with a steady receiver and sender
      test_invalid_width();
      test_zero_and_small();
      test_signed_extremes();
      test_length_boundaries();

      // random part: receiver slow, then sender slow, then flat out
      test_random_traffic(19, 70, 132, 1'b1);
      test_random_traffic(70, 19, 132, 1'b0);
      test_random_traffic(0, 0, 132, 1'b1);

      wait_until_drained();
      repeat (TAIL_CYCLES) @(posedge clock);

      if (mismatches == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
